// ----- rtl/trf_pkg.sv -----
// Shared types and constants for the telemetry retransmit FIFO.
package trf_pkg;

   localparam int FRAME_BYTES = 10;
   localparam int COUNT_W     = 4;
   localparam int ID_W        = 5;
   localparam int BYTE_W      = 8;
   localparam int FID_W       = 8;

   localparam logic REQ_PUSH  = 1'b0;
   localparam logic REQ_FRAME = 1'b1;

   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [BYTE_W-1:0]  byte_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic push;
      logic frame;
      logic pop;
   } trf_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic can_pop;
   } trf_stat_type;

endpackage

// ----- rtl/trf_ctrl.sv -----
// Controller state machine: decodes transactions and sequences frame reads.
module trf_ctrl
   import trf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         req_type,
   input  trf_stat_type stat,
   output trf_cmd_type  cmd,
   output logic         busy,
   output logic         rsp_valid
);

   typedef enum logic {
      ST_IDLE,
      ST_POP
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      accept;

   assign accept    = start && (state_ff == ST_IDLE);
   assign cmd.push  = accept && (req_type == REQ_PUSH);
   assign cmd.frame = accept && (req_type == REQ_FRAME);
   assign cmd.pop   = (state_ff == ST_POP) && stat.can_pop;
   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (cmd.frame) begin
                  state_ff <= ST_POP;
               end
            end
            ST_POP: begin
               // last read data lands in the payload on this same edge
               if (!stat.can_pop) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ----- rtl/trf_datapath.sv -----
// Datapath: byte ring memory, pointers, id tracking and frame payload registers.
module trf_datapath
   import trf_pkg::*;
#(
   parameter int BUFFER_DEPTH = 128
)
(
   input  logic         clock,
   input  logic         reset,
   input  trf_cmd_type  cmd,
   input  byte_type     data_byte,
   input  logic [FID_W-1:0] frame_id,
   output trf_stat_type stat,
   output count_type    byte_count,
   output logic [FID_W-1:0] echo_id,
   output byte_type     payload [FRAME_BYTES]
);

   localparam int PTR_W = $clog2(BUFFER_DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(BUFFER_DEPTH - 1);

   byte_type          mem [BUFFER_DEPTH];
   byte_type          mem_q_ff;
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [PTR_W-1:0]  ack_ptr_ff;
   logic [PTR_W-1:0]  wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_in;
   logic [ID_W-1:0]   exp_id_ff;
   count_type         count_ff;
   count_type         slot_ff;
   logic              pend_ff;
   logic [FID_W-1:0]  echo_ff;
   byte_type          payload_ff [FRAME_BYTES];
   logic              full;
   logic              id_match;

   assign wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
   // full test is against the read pointer; unacked bytes may be overwritten
   assign full      = (wr_ptr_in == rd_ptr_ff);
   assign id_match  = (frame_id == {{(FID_W-ID_W){1'b0}}, exp_id_ff});

   assign stat.can_pop = (count_ff != COUNT_W'(FRAME_BYTES)) && (rd_ptr_ff != wr_ptr_ff);
   assign byte_count   = count_ff;
   assign echo_id      = echo_ff;
   assign payload      = payload_ff;

   always_ff @(posedge clock) begin
      if (cmd.push && !full) begin
         mem[wr_ptr_ff] <= data_byte;
      end
      if (cmd.pop) begin
         mem_q_ff <= mem[rd_ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         ack_ptr_ff <= '0;
         exp_id_ff  <= '0;
         count_ff   <= '0;
         pend_ff    <= 1'b0;
      end else begin
         pend_ff <= cmd.pop;
         if (cmd.push && !full) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (cmd.frame) begin
            if (id_match) begin
               ack_ptr_ff <= rd_ptr_ff;
            end else begin
               rd_ptr_ff <= ack_ptr_ff;
            end
            exp_id_ff <= frame_id[ID_W-1:0] + 1'b1;
            count_ff  <= '0;
         end
         if (cmd.pop) begin
            rd_ptr_ff <= rd_ptr_in;
            count_ff  <= count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.frame) begin
         echo_ff <= frame_id;
         for (int i = 0; i < FRAME_BYTES; i++) begin
            payload_ff[i] <= '0;
         end
      end
      if (cmd.pop) begin
         slot_ff <= count_ff;
      end
      if (pend_ff) begin
         payload_ff[slot_ff] <= mem_q_ff;
      end
   end

endmodule

// ----- rtl/telemetry_retransmit_fifo_core.sv -----
// Top level of the telemetry byte FIFO with go-back frame retransmit.
//
//  channel   handshake            payload
//  request   start / busy         req_type, req_data_byte, req_frame_id
//  response  rsp_valid (strobe)   rsp_byte_count, rsp_echo_id, rsp_payload_0..9
//
// A push transaction completes on its accept edge; busy stays low.
// A frame request holds busy while it reads up to 10 bytes through the single
// read port of the byte memory, then strobes the response for one cycle with
// busy already low.
// Reset clears pointers and the expected id; memory contents are not cleared.
// The response cannot be stalled.
module telemetry_retransmit_fifo_core
   import trf_pkg::*;
#(
   parameter int BUFFER_DEPTH = 128
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic       req_type,
   input  logic [7:0] req_data_byte,
   input  logic [7:0] req_frame_id,
   output logic       rsp_valid,
   output logic [3:0] rsp_byte_count,
   output logic [7:0] rsp_echo_id,
   output logic [7:0] rsp_payload_0,
   output logic [7:0] rsp_payload_1,
   output logic [7:0] rsp_payload_2,
   output logic [7:0] rsp_payload_3,
   output logic [7:0] rsp_payload_4,
   output logic [7:0] rsp_payload_5,
   output logic [7:0] rsp_payload_6,
   output logic [7:0] rsp_payload_7,
   output logic [7:0] rsp_payload_8,
   output logic [7:0] rsp_payload_9
);

   trf_cmd_type  cmd;
   trf_stat_type stat;
   byte_type     payload [FRAME_BYTES];

   trf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_type  (req_type),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   trf_datapath #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .data_byte  (req_data_byte),
      .frame_id   (req_frame_id),
      .stat       (stat),
      .byte_count (rsp_byte_count),
      .echo_id    (rsp_echo_id),
      .payload    (payload)
   );

   assign rsp_payload_0 = payload[0];
   assign rsp_payload_1 = payload[1];
   assign rsp_payload_2 = payload[2];
   assign rsp_payload_3 = payload[3];
   assign rsp_payload_4 = payload[4];
   assign rsp_payload_5 = payload[5];
   assign rsp_payload_6 = payload[6];
   assign rsp_payload_7 = payload[7];
   assign rsp_payload_8 = payload[8];
   assign rsp_payload_9 = payload[9];

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_byte_count <= 4'(FRAME_BYTES)))
      else $error("response byte count above frame size");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response strobed while frame read still running");

   a_frame_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_type == REQ_FRAME) |=> busy)
      else $error("frame request did not start a read sequence");

   a_push_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_type == REQ_PUSH) |=> (!busy && !rsp_valid))
      else $error("push transaction produced a response or held busy");

endmodule
